### hw/rtl/led_frame_deframer_assert.svh
// Assertion macros shared by the LED frame deframer RTL.
`ifndef LED_FRAME_DEFRAMER_ASSERT_SVH
`define LED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define LFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ledfd_pkg.sv
// Types and constants of the LED frame deframer.
package ledfd_pkg;

  localparam logic [7:0] HDR0  = 8'h4D;  // 'M'
  localparam logic [7:0] HDR1  = 8'h4A;  // 'J'
  localparam logic [7:0] HDR2  = 8'h58;  // 'X'
  localparam logic [7:0] CMD_1 = 8'h01;

  // Longest payload accepted, key byte included.
  localparam logic [7:0] MAX_LEN = 8'd5;

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_HUNT2,
    PH_CMD,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] led_byte;
    logic       has_data;
    logic       latch;
  } result_t;

endpackage

### hw/rtl/led_frame_deframer.sv
// Top level of the LED frame deframer: parser plus output register and skid stage.
//
// Takes one received serial byte per request and looks for frames of the form
// 'M' 'J' 'X', command, length, key, payload. For command 1 every payload byte
// after the key comes out as (byte - key) mod 256 with has_data set, and the
// last one carries latch; a frame of length 0 or 1 gives one latch-only result
// (led_byte 0, has_data 0). Other commands are skipped by their length, and a
// length above MAX_LEN (5) drops the frame and restarts the header hunt. A byte
// that breaks the header match restarts the hunt, counting as 'M' if it is one.
// Rate: one byte per clock while in_stall is low; each byte is parsed in the
// cycle it is accepted and its result, if any, is registered into the output
// register, or into the one-entry skid stage while an older result waits on
// out_stall; in_stall rises only once two results are waiting.
module led_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_led_byte,
  output logic       out_has_data,
  output logic       out_latch
);
  import ledfd_pkg::*;
  `include "led_frame_deframer_assert.svh"

  logic    in_accept;
  logic    out_take;
  result_t res;

  // Output register and skid entry; valid bits live inside the structs.
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  // Skid full means a result is waiting behind a stalled output: hold off input.
  assign in_stall  = skid_r.valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_r.valid && !out_stall;

  ledfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_accept),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.valid || out_take) begin
      // Output slot frees up: the oldest waiting result moves in first.
      if (skid_r.valid) begin
        out_nxt  = skid_r;
        skid_nxt = res;
      end else begin
        out_nxt = res;
      end
    end else if (res.valid) begin
      // Output held by the downstream stall; park the new result.
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r.valid  <= out_nxt.valid;
      skid_r.valid <= skid_nxt.valid;
    end
    out_r.led_byte  <= out_nxt.led_byte;
    out_r.has_data  <= out_nxt.has_data;
    out_r.latch     <= out_nxt.latch;
    skid_r.led_byte <= skid_nxt.led_byte;
    skid_r.has_data <= skid_nxt.has_data;
    skid_r.latch    <= skid_nxt.latch;
  end

  assign out_valid    = out_r.valid;
  assign out_led_byte = out_r.led_byte;
  assign out_has_data = out_r.has_data;
  assign out_latch    = out_r.latch;

  `LFD_ASSERT_IMPL(a_skid_behind_out, skid_r.valid, out_r.valid,
    "skid entry held with empty output register")
  `LFD_ASSERT_IMPL(a_latch_only_form, out_r.valid && !out_r.has_data,
    out_r.latch && out_r.led_byte == 8'd0, "malformed latch-only result")
  `LFD_ASSERT_NEXT(a_skid_drains, skid_r.valid && !out_stall, !skid_r.valid ||
    !$past(in_accept) || $past(res.valid), "skid entry not drained")

endmodule

### hw/rtl/ledfd_parser.sv
// Byte-synchronous frame parser: header hunt, command, length, descramble.
module ledfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output ledfd_pkg::result_t res
);
  import ledfd_pkg::*;
  `include "led_frame_deframer_assert.svh"

  phase_t     phase_r, phase_nxt;
  logic [2:0] frame_len_r, frame_len_nxt;
  logic [2:0] byte_index_r, byte_index_nxt;
  logic [7:0] key_r, key_nxt;
  logic       cmd_ok_r, cmd_ok_nxt;

  logic [3:0] index_inc;
  logic       last_byte;

  assign index_inc = {1'b0, byte_index_r} + 4'd1;
  assign last_byte = index_inc >= {1'b0, frame_len_r};

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    byte_index_nxt = byte_index_r;
    key_nxt        = key_r;
    cmd_ok_nxt     = cmd_ok_r;
    if (step) begin
      case (phase_r)
        PH_HUNT0: begin
          if (rx_byte == HDR0) phase_nxt = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (rx_byte == HDR1)      phase_nxt = PH_HUNT2;
          else if (rx_byte == HDR0) phase_nxt = PH_HUNT1;
          else                      phase_nxt = PH_HUNT0;
        end
        PH_HUNT2: begin
          if (rx_byte == HDR2)      phase_nxt = PH_CMD;
          else if (rx_byte == HDR0) phase_nxt = PH_HUNT1;
          else                      phase_nxt = PH_HUNT0;
        end
        PH_CMD: begin
          cmd_ok_nxt = (rx_byte == CMD_1);
          phase_nxt  = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte > MAX_LEN || rx_byte == 8'd0) begin
            phase_nxt = PH_HUNT0;
          end else begin
            frame_len_nxt  = rx_byte[2:0];
            byte_index_nxt = 3'd0;
            phase_nxt      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (byte_index_r == 3'd0) begin
            key_nxt = rx_byte;
            if (frame_len_r <= 3'd1) phase_nxt = PH_HUNT0;
            else                     byte_index_nxt = 3'd1;
          end else if (last_byte) begin
            phase_nxt = PH_HUNT0;
          end else begin
            byte_index_nxt = index_inc[2:0];
          end
        end
        default: phase_nxt = PH_HUNT0;
      endcase
    end
  end

  // Outputs
  always_comb begin
    res = '0;
    if (step && cmd_ok_r) begin
      case (phase_r)
        PH_LEN: begin
          if (rx_byte == 8'd0) begin
            res.valid = 1'b1;
            res.latch = 1'b1;
          end
        end
        PH_DATA: begin
          if (byte_index_r == 3'd0) begin
            if (frame_len_r <= 3'd1) begin
              res.valid = 1'b1;
              res.latch = 1'b1;
            end
          end else begin
            res.valid    = 1'b1;
            res.has_data = 1'b1;
            res.led_byte = rx_byte - key_r;
            res.latch    = last_byte;
          end
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT0;
      frame_len_r  <= 3'd0;
      byte_index_r <= 3'd0;
      key_r        <= 8'd0;
      cmd_ok_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      frame_len_r  <= frame_len_nxt;
      byte_index_r <= byte_index_nxt;
      key_r        <= key_nxt;
      cmd_ok_r     <= cmd_ok_nxt;
    end
  end

  `LFD_ASSERT_IMPL(a_data_len_ok, phase_r == PH_DATA,
    frame_len_r != 3'd0 && byte_index_r < frame_len_r, "payload index out of frame")
  `LFD_ASSERT_IMPL(a_data_needs_cmd, res.has_data,
    cmd_ok_r && phase_r == PH_DATA, "data result outside a command 1 payload")

endmodule
